### src/lar_pkg.sv
`default_nettype none

package lar_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef struct packed {
        logic        op;
        logic [7:0]  byte_in;
        logic [31:0] timestamp;
        logic [7:0]  entry_index;
        logic [5:0]  char_pos;
    } t_item;

    typedef struct packed {
        logic [8:0]  entry_count;
        logic        hit;
        logic [31:0] stamp_out;
        logic [7:0]  char_out;
        logic [5:0]  line_len;
    } t_result;

endpackage

`default_nettype wire

### src/line_assembling_log_ring_core.sv
// Log ring core: text bytes are assembled into lines and committed on newline into a
// ring of RING_ENTRIES lines that overwrites its oldest line when full. An item is taken
// in every cycle (busy stays low) and its result appears on o_result with o_done after
// the registered memory read and then the result register. Results cannot be held off.
// The line being assembled is written straight into a spare text row, so the text memory
// holds RING_ENTRIES+1 rows of LINE_BYTES and a commit copies no text. Memories need no
// clearing after reset.
`default_nettype none

module line_assembling_log_ring_core
    import lar_pkg::*;
#(
    parameter int RING_ENTRIES = 256,
    parameter int LINE_BYTES   = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    localparam int ROWS   = RING_ENTRIES + 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int SUM_W  = ROW_W + 1;
    localparam int CMP_W  = (ROW_W > 8) ? ROW_W : 8;
    localparam logic [SUM_W-1:0] ROWS_S    = SUM_W'(ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] FULL_CNT  = ROW_W'(RING_ENTRIES);
    localparam logic [POS_W-1:0] FILL_MAX  = POS_W'(LINE_BYTES - 1);

    logic             r_enabled;
    logic [ROW_W-1:0] r_wrow, n_wrow;
    logic [ROW_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_fill, n_fill;

    logic             r_v1, r_hit1;
    logic [5:0]       r_pos1;
    logic [8:0]       r_count1;

    logic             r_done;
    t_result          r_result, n_result;

    logic             accept, is_app, is_lf, text_we, commit, read_hit;
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] rd_row;

    logic [31:0]      rd_stamp;
    logic [POS_W-1:0] rd_len;
    logic [7:0]       rd_char;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_app = accept && (i_item.op == OP_APPEND);
    assign is_lf  = is_app && (i_item.byte_in == CH_LF);
    assign text_we = is_app && (i_item.byte_in != CH_LF) && (i_item.byte_in != CH_CR)
                     && (r_fill < FILL_MAX);
    assign commit = is_lf && r_enabled;
    assign read_hit = accept && (i_item.op == OP_READ) && r_enabled
                      && (CMP_W'(i_item.entry_index) < CMP_W'(r_count));

    // oldest entry sits valid_count rows behind the write row, modulo ROWS
    assign sum = {1'b0, r_wrow} + (ROWS_S - {1'b0, r_count})
                 + SUM_W'(i_item.entry_index);

    always_comb begin
        if (sum >= ROWS_S) begin
            rd_row = ROW_W'(sum - ROWS_S);
        end else begin
            rd_row = ROW_W'(sum);
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_wrow  = r_wrow;
        n_count = r_count;
        if (is_lf) begin
            n_fill = '0;
        end else if (text_we) begin
            n_fill = r_fill + 1'b1;
        end
        if (commit) begin
            n_wrow = (r_wrow == LAST_ROW) ? '0 : r_wrow + 1'b1;
            if (r_count != FULL_CNT) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    lar_ring_mem #(
        .ROWS       (ROWS),
        .LINE_BYTES (LINE_BYTES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_text_we  (text_we),
        .i_wr_row   (r_wrow),
        .i_wr_pos   (r_fill),
        .i_wr_char  (i_item.byte_in),
        .i_ent_we   (commit),
        .i_wr_stamp (i_item.timestamp),
        .i_wr_len   (r_fill),
        .i_rd_en    (read_hit),
        .i_rd_row   (rd_row),
        .i_rd_pos   (i_item.char_pos[POS_W-1:0]),
        .o_rd_stamp (rd_stamp),
        .o_rd_len   (rd_len),
        .o_rd_char  (rd_char)
    );

    always_comb begin
        n_result             = '0;
        n_result.entry_count = r_count1;
        if (r_hit1) begin
            n_result.hit       = 1'b1;
            n_result.stamp_out = rd_stamp;
            n_result.line_len  = 6'(rd_len);
            if (r_pos1 < 6'(rd_len)) begin
                n_result.char_out = rd_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_wrow    <= '0;
            r_count   <= '0;
            r_fill    <= '0;
            r_v1      <= 1'b0;
            r_hit1    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            r_wrow <= n_wrow;
            r_count <= n_count;
            r_fill <= n_fill;
            r_v1   <= accept;
            r_hit1 <= read_hit;
            r_done <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos1   <= i_item.char_pos;
        r_count1 <= 9'(n_count);
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond ring size");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrow <= LAST_ROW)
        else $error("write row out of range");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("line fill beyond capacity");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("result missing two cycles after item");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.hit) |->
            (o_result.stamp_out == 32'd0 && o_result.char_out == 8'd0
             && o_result.line_len == 6'd0))
        else $error("miss result carries data");

endmodule

`default_nettype wire

### src/lar_ring_mem.sv
`default_nettype none

module lar_ring_mem
#(
    parameter int ROWS       = 257,
    parameter int LINE_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_text_we,
    input  logic [$clog2(ROWS)-1:0]       i_wr_row,
    input  logic [$clog2(LINE_BYTES)-1:0] i_wr_pos,
    input  logic [7:0]                    i_wr_char,
    input  logic                          i_ent_we,
    input  logic [31:0]                   i_wr_stamp,
    input  logic [$clog2(LINE_BYTES)-1:0] i_wr_len,
    input  logic                          i_rd_en,
    input  logic [$clog2(ROWS)-1:0]       i_rd_row,
    input  logic [$clog2(LINE_BYTES)-1:0] i_rd_pos,
    output logic [31:0]                   o_rd_stamp,
    output logic [$clog2(LINE_BYTES)-1:0] o_rd_len,
    output logic [7:0]                    o_rd_char
);

    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int TEXT_D = ROWS << POS_W;

    logic [31:0]      r_stamps [ROWS];
    logic [POS_W-1:0] r_lens   [ROWS];
    logic [7:0]       r_text   [TEXT_D];

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_stamps[i_wr_row] <= i_wr_stamp;
            r_lens[i_wr_row]   <= i_wr_len;
        end
        if (i_rd_en) begin
            o_rd_stamp <= r_stamps[i_rd_row];
            o_rd_len   <= r_lens[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text_we) begin
            r_text[{i_wr_row, i_wr_pos}] <= i_wr_char;
        end
        if (i_rd_en) begin
            o_rd_char <= r_text[{i_rd_row, i_rd_pos}];
        end
    end

endmodule

`default_nettype wire
